@@ rtl/core/dphs_pkg.sv @@
// shared types and constants of the deadline/profit heap scheduler
`timescale 1ns / 1ps
package dphs_pkg;

  localparam int unsigned HEAP_DEPTH_DEF = 1024;
  localparam int unsigned DL_W           = 16;
  localparam int unsigned PAY_W          = 16;
  localparam int unsigned TOTAL_W        = 26;

  typedef struct packed {
    logic             first_item;
    logic [DL_W-1:0]  deadline;
    logic [PAY_W-1:0] pay;
  } dphs_job_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_pay;
    logic               accepted;
    logic               evicted_valid;
    logic [PAY_W-1:0]   evicted_pay;
    logic               order_error;
  } dphs_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_CMP,
    ST_TOP,
    ST_DN,
    ST_DN_R,
    ST_DN_CMP,
    ST_DONE
  } dphs_state_e;

endpackage

@@ rtl/core/dphs_stream_if.sv @@
// valid/ready channel carrying one item of type T
`timescale 1ns / 1ps
interface dphs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/deadline_profit_heap_scheduler.sv @@
// job sequencing with deadlines: min-heap of selected pays, sequenced over one read port
`timescale 1ns / 1ps
// Jobs arrive on job_i sorted by ascending deadline; each gives one result on res_o with the
// running total of selected pays, accepted/evicted flags and an order flag. The heap lives in
// a single memory (one write and one registered read per cycle), and all heap walking goes
// through that one read port, so the block takes one job at a time. A pushed job climbs one
// level per parent read and compare until it reaches the root or stops; a job that may
// replace the minimum first reads the root, then sinks one level per read of the left child,
// read of the right child if present and compare; a rejected job reads the root only when
// the heap is not empty. The next job can be taken in the cycle after the result is loaded.
// A finished result waits in an output register, and the next job is accepted while
// it waits.
module deadline_profit_heap_scheduler #(
  parameter int unsigned HEAP_DEPTH = dphs_pkg::HEAP_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dphs_stream_if.sink   job_i,
  dphs_stream_if.source res_o
);
  import dphs_pkg::*;

  localparam int unsigned IW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned LW = IW + 2;
  localparam int unsigned XW = DL_W + 1;

  logic [PAY_W-1:0] heap_mem [HEAP_DEPTH];

  dphs_state_e        state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [DL_W-1:0]    prev_q, prev_d;
  logic [PAY_W-1:0]   pay_q, pay_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [PAY_W-1:0]   lval_q, lval_d;
  logic               has_right_q, has_right_d;
  logic               acc_q, acc_d;
  logic               ev_valid_q, ev_valid_d;
  logic [PAY_W-1:0]   ev_pay_q, ev_pay_d;
  logic               oerr_q, oerr_d;
  logic               out_valid_q;
  dphs_res_t          out_data_q;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [PAY_W-1:0]   mem_wdata;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  logic [PAY_W-1:0]   rdata_q;

  logic               job_take;
  logic               out_load;
  logic [CW-1:0]      cnt_eff;
  logic [XW-1:0]      limit;
  logic               do_push;
  logic               order_err;
  logic [IW-1:0]      parent;
  logic [LW-1:0]      left_x;
  logic [LW-1:0]      right_x;
  logic [LW-1:0]      count_x;
  logic               right_here;
  logic               take_right;
  logic [PAY_W-1:0]   pick_val;
  logic [IW-1:0]      pick_idx;

  assign job_take = job_i.valid && job_i.ready;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);

  // accept-time decision
  assign cnt_eff   = job_i.data.first_item ? '0 : count_q;
  assign limit     = ({1'b0, job_i.data.deadline} > XW'(HEAP_DEPTH)) ? XW'(HEAP_DEPTH)
                                                                     : {1'b0, job_i.data.deadline};
  assign do_push   = XW'(cnt_eff) < limit;
  assign order_err = job_i.data.first_item ? 1'b0 : (job_i.data.deadline < prev_q);

  // heap index arithmetic
  assign parent     = (idx_q - IW'(1)) >> 1;
  assign left_x     = LW'({idx_q, 1'b1});
  assign right_x    = left_x + LW'(1);
  assign count_x    = LW'(count_q);
  assign right_here = right_x < count_x;
  assign take_right = has_right_q && (rdata_q < lval_q);
  assign pick_val   = take_right ? rdata_q : lval_q;
  assign pick_idx   = take_right ? right_x[IW-1:0] : left_x[IW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_take) begin
          if (do_push) begin
            state_d = ST_UP;
          end else if (cnt_eff != '0) begin
            state_d = ST_TOP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_UP: begin
        state_d = (idx_q == '0) ? ST_DONE : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        state_d = (rdata_q <= pay_q) ? ST_DONE : ST_UP;
      end
      ST_TOP: begin
        state_d = (rdata_q < pay_q) ? ST_DN : ST_DONE;
      end
      ST_DN: begin
        state_d = (left_x >= count_x) ? ST_DONE : ST_DN_R;
      end
      ST_DN_R: begin
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        state_d = (pick_val >= pay_q) ? ST_DONE : ST_DN;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and memory controls
  always_comb begin
    count_d     = count_q;
    total_d     = total_q;
    prev_d      = prev_q;
    pay_d       = pay_q;
    idx_d       = idx_q;
    lval_d      = lval_q;
    has_right_d = has_right_q;
    acc_d       = acc_q;
    ev_valid_d  = ev_valid_q;
    ev_pay_d    = ev_pay_q;
    oerr_d      = oerr_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = pay_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    case (state_q)
      ST_IDLE: begin
        if (job_take) begin
          pay_d      = job_i.data.pay;
          prev_d     = job_i.data.deadline;
          oerr_d     = order_err;
          acc_d      = do_push;
          ev_valid_d = 1'b0;
          ev_pay_d   = '0;
          idx_d      = cnt_eff[IW-1:0];
          total_d    = job_i.data.first_item ? '0 : total_q;
          count_d    = cnt_eff;
          if (do_push) begin
            count_d = cnt_eff + CW'(1);
            total_d = (job_i.data.first_item ? '0 : total_q) + TOTAL_W'(job_i.data.pay);
          end else begin
            // fetch the minimum for the replace test
            mem_re    = (cnt_eff != '0);
            mem_raddr = '0;
          end
        end
      end
      ST_UP: begin
        if (idx_q == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent;
        end
      end
      ST_UP_CMP: begin
        mem_we = 1'b1;
        if (rdata_q > pay_q) begin
          // parent moves down one level
          mem_wdata = rdata_q;
          idx_d     = parent;
        end
      end
      ST_TOP: begin
        if (rdata_q < pay_q) begin
          acc_d      = 1'b1;
          ev_valid_d = 1'b1;
          ev_pay_d   = rdata_q;
          total_d    = total_q - TOTAL_W'(rdata_q) + TOTAL_W'(pay_q);
          idx_d      = '0;
        end
      end
      ST_DN: begin
        if (left_x >= count_x) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = left_x[IW-1:0];
        end
      end
      ST_DN_R: begin
        lval_d      = rdata_q;
        has_right_d = right_here;
        if (right_here) begin
          mem_re    = 1'b1;
          mem_raddr = right_x[IW-1:0];
        end
      end
      ST_DN_CMP: begin
        mem_we = 1'b1;
        if (pick_val < pay_q) begin
          // smaller child moves up one level
          mem_wdata = pick_val;
          idx_d     = pick_idx;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= heap_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      prev_q  <= prev_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q       <= pay_d;
    idx_q       <= idx_d;
    lval_q      <= lval_d;
    has_right_q <= has_right_d;
    acc_q       <= acc_d;
    ev_valid_q  <= ev_valid_d;
    ev_pay_q    <= ev_pay_d;
    oerr_q      <= oerr_d;
    if (out_load) begin
      out_data_q.total_pay     <= total_q;
      out_data_q.accepted      <= acc_q;
      out_data_q.evicted_valid <= ev_valid_q;
      out_data_q.evicted_pay   <= ev_pay_q;
      out_data_q.order_error   <= oerr_q;
    end
  end

  assign job_i.ready = (state_q == ST_IDLE);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

endmodule

@@ bench/testbench.sv @@
// self-checking bench for the deadline/profit heap scheduler: directed, random, heap-fill jobs
`timescale 1ns / 1ps
module testbench;
  import dphs_pkg::*;

  localparam time         CLK_PERIOD  = 8ns;
  localparam int unsigned HEAP_CAP    = HEAP_DEPTH_DEF;
  localparam int unsigned FILL_SIZE   = 255;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned MAX_REPORTS = 100;
  localparam int unsigned N_DIRECTED  = 24;

  // one job of the directed table; when typed is set the listed result is checked as is
  typedef struct packed {
    logic               first_item;
    logic [DL_W-1:0]    deadline;
    logic [PAY_W-1:0]   pay;
    logic               typed;
    logic [TOTAL_W-1:0] total_pay;
    logic               accepted;
    logic               evicted_valid;
    logic [PAY_W-1:0]   evicted_pay;
    logic               order_error;
  } job_row_t;

  localparam job_row_t DIRECTED_JOBS [N_DIRECTED] = '{
    // first  deadline      pay           typed total      acc   ev    ev_pay      order
    '{1'b1, 16'd1,      16'd100,    1'b1, 26'd100,   1'b1, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd1,      16'd100,    1'b1, 26'd100,   1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd1,      16'd50,     1'b1, 26'd100,   1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd1,      16'hFFFF,   1'b1, 26'd65535, 1'b1, 1'b1, 16'd100, 1'b0},
    '{1'b0, 16'd1,      16'd0,      1'b1, 26'd65535, 1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b1, 16'd0,      16'd500,    1'b1, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd2,      16'd10,     1'b1, 26'd10,    1'b1, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd0,      16'd20,     1'b1, 26'd20,    1'b1, 1'b1, 16'd10,  1'b1},
    '{1'b0, 16'd0,      16'd5,      1'b1, 26'd20,    1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b1, 16'hFFFF,   16'hFFFF,   1'b1, 26'd65535, 1'b1, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd1024,   16'd0,      1'b1, 26'd65535, 1'b1, 1'b0, 16'd0,   1'b1},
    '{1'b0, 16'd1025,   16'd1,      1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd32768,  16'd2,      1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd5,      16'd3,      1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd4,      16'd4,      1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd4,      16'd0,      1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b1, 16'd3,      16'd300,    1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd3,      16'd200,    1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd3,      16'd100,    1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd3,      16'd400,    1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd3,      16'd150,    1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'd3,      16'd250,    1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b1, 16'h5555,   16'hAAAA,   1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0},
    '{1'b0, 16'hAAAA,   16'h5555,   1'b0, 26'd0,     1'b0, 1'b0, 16'd0,   1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  dphs_stream_if #(.T(dphs_job_t)) job_if ();
  dphs_stream_if #(.T(dphs_res_t)) res_if ();

  deadline_profit_heap_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_if),
    .res_o  (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // mirror of the selection: min-heap of chosen pays, their sum and the last deadline
  logic [PAY_W-1:0]   chosen_pay [HEAP_CAP];
  int unsigned        chosen_cnt;
  logic [TOTAL_W-1:0] chosen_total;
  logic [DL_W-1:0]    last_deadline;

  dphs_res_t   pending_res [$];
  int unsigned mismatches;
  int unsigned jobs_sent;
  int unsigned idle_cycles;
  bit          rush;
  bit          hold_req;

  function automatic dphs_res_t select_job(dphs_job_t job);
    dphs_res_t   res;
    int unsigned slots;
    int unsigned pos;
    int unsigned kid;
    res = '0;
    if (job.first_item) begin
      chosen_cnt    = 0;
      chosen_total  = '0;
      last_deadline = '0;
    end
    res.order_error = (job.deadline < last_deadline);
    last_deadline   = job.deadline;
    slots = (job.deadline > HEAP_CAP) ? HEAP_CAP : job.deadline;
    if (chosen_cnt < slots) begin
      // free slot: sift the new pay up from the bottom
      pos = chosen_cnt;
      while (pos > 0 && chosen_pay[(pos - 1) / 2] > job.pay) begin
        chosen_pay[pos] = chosen_pay[(pos - 1) / 2];
        pos = (pos - 1) / 2;
      end
      chosen_pay[pos] = job.pay;
      chosen_cnt++;
      chosen_total = chosen_total + job.pay;
      res.accepted = 1'b1;
    end else if (chosen_cnt > 0 && chosen_pay[0] < job.pay) begin
      // full: drop the smallest pay and sink the new one from the root
      res.evicted_pay   = chosen_pay[0];
      res.evicted_valid = 1'b1;
      res.accepted      = 1'b1;
      pos = 0;
      while (2 * pos + 1 < chosen_cnt) begin
        kid = 2 * pos + 1;
        if (kid + 1 < chosen_cnt && chosen_pay[kid + 1] < chosen_pay[kid]) kid++;
        if (chosen_pay[kid] >= job.pay) break;
        chosen_pay[pos] = chosen_pay[kid];
        pos = kid;
      end
      chosen_pay[pos] = job.pay;
      chosen_total = chosen_total - res.evicted_pay + job.pay;
    end
    res.total_pay = chosen_total;
    return res;
  endfunction

  // offers one job, waits for it to be taken and queues its expected result
  task automatic offer_job(input dphs_job_t job, input bit typed, input dphs_res_t want);
    int unsigned gap;
    dphs_res_t   pred;
    gap = rush ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      job_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    job_if.valid <= 1'b1;
    job_if.data  <= job;
    do @(posedge clk_i); while (!job_if.ready);
    pred = select_job(job);
    pending_res.push_back(typed ? want : pred);
    jobs_sent++;
  endtask

  // one run of jobs: mostly sorted runs with random pays, some out of order, some noise
  task automatic random_run(input bit busy);
    int unsigned     kind;
    int unsigned     len;
    bit              narrow;
    logic [DL_W-1:0] dl;
    dphs_job_t       job;
    kind   = busy ? 0 : $urandom_range(0, 9);
    len    = busy ? 40 : $urandom_range(1, 40);
    rush   = busy || ($urandom_range(0, 3) == 0);
    narrow = 1'($urandom_range(0, 1));
    dl     = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    if (kind >= 8) len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if (kind >= 8) begin
        job.first_item = 1'($urandom_range(0, 1));
        job.deadline   = 16'($urandom);
        job.pay        = 16'($urandom);
      end else begin
        if (i != 0) begin
          if (kind == 7 && dl != 0 && $urandom_range(0, 4) == 0)
            dl = dl - 16'($urandom_range(1, dl));
          else if (dl < 16'hFFFD)
            dl = dl + 16'($urandom_range(0, 2));
        end
        job.first_item = (i == 0) || (kind == 7 && $urandom_range(0, 9) == 0);
        job.deadline   = dl;
        job.pay        = narrow ? 16'($urandom_range(0, 15)) : 16'($urandom);
      end
      offer_job(job, 1'b0, '0);
    end
  endtask

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    dphs_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_res.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got total %0d", $time,
                 res_if.data.total_pay);
      end else begin
        want = pending_res.pop_front();
        report_field("total_pay", want.total_pay, res_if.data.total_pay);
        report_field("accepted", want.accepted, res_if.data.accepted);
        report_field("evicted_valid", want.evicted_valid, res_if.data.evicted_valid);
        report_field("evicted_pay", want.evicted_pay, res_if.data.evicted_pay);
        report_field("order_error", want.order_error, res_if.data.order_error);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((job_if.valid && job_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("** deadline_profit_heap_scheduler: FAILED **");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        // long back-pressure so the block fills up and stalls its job input
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = rush ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  initial begin : job_source
    dphs_job_t   job;
    dphs_res_t   want;
    int unsigned target;
    rst_ni        <= 1'b0;
    job_if.valid  <= 1'b0;
    job_if.data   <= '0;
    chosen_cnt    = 0;
    chosen_total  = '0;
    last_deadline = '0;
    mismatches    = 0;
    jobs_sent     = 0;
    idle_cycles   = 0;
    rush          = 1'b0;
    hold_req      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_JOBS[i]) begin
      job.first_item     = DIRECTED_JOBS[i].first_item;
      job.deadline       = DIRECTED_JOBS[i].deadline;
      job.pay            = DIRECTED_JOBS[i].pay;
      want.total_pay     = DIRECTED_JOBS[i].total_pay;
      want.accepted      = DIRECTED_JOBS[i].accepted;
      want.evicted_valid = DIRECTED_JOBS[i].evicted_valid;
      want.evicted_pay   = DIRECTED_JOBS[i].evicted_pay;
      want.order_error   = DIRECTED_JOBS[i].order_error;
      offer_job(job, DIRECTED_JOBS[i].typed, want);
    end

    hold_req = 1'b1;
    random_run(1'b1);
    while (jobs_sent < 200) random_run(1'b0);

    // fill a deep heap with falling pays so every push climbs to the root,
    // then replace the minimum so each new pay sinks toward a leaf
    rush = 1'b1;
    for (int i = 0; i < FILL_SIZE + 16; i++) begin
      job.first_item = (i == 0);
      job.deadline   = 16'(FILL_SIZE);
      job.pay        = (i < FILL_SIZE) ? 16'(16'hFFFF - i) : 16'(16'hFFFF - $urandom_range(0, 1));
      offer_job(job, 1'b0, '0);
    end

    target = jobs_sent + 180;
    while (jobs_sent < target) random_run(1'b0);
    job_if.valid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("** deadline_profit_heap_scheduler: PASSED **");
    end else begin
      $display("** deadline_profit_heap_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
